>>> sv/flash_record_log_pointer_unit_macros.svh
// Assertion macros used by the back end (frlp_back) of the log pointer unit.
`ifndef FLASH_RECORD_LOG_POINTER_UNIT_MACROS_SVH
`define FLASH_RECORD_LOG_POINTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

>>> sv/frlp_pkg.sv
`default_nettype none

package frlp_pkg;

   localparam int SECTOR_BYTES       = 4096;
   localparam int MAX_REGION_SECTORS = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam int ADDR_W = 24;
   localparam int PTR_W  = 25;
   localparam int LEN_W  = 10;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_SCAN   = 2'd2;
   localparam logic [1:0] CMD_HEADER = 2'd3;

   localparam logic [2:0] OP_ERASE  = 3'd0;
   localparam logic [2:0] OP_WHDR   = 3'd1;
   localparam logic [2:0] OP_WPAY   = 3'd2;
   localparam logic [2:0] OP_RHDR   = 3'd3;
   localparam logic [2:0] OP_STATUS = 3'd4;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_REJECT = 2'd1;
   localparam logic [1:0] STAT_END    = 2'd2;

   localparam logic [15:0] MIN_LEN     = 16'd12;
   localparam logic [15:0] MAX_LEN     = 16'd512;
   localparam logic [15:0] ERASED_WORD = 16'hFFFF;
   localparam logic [LEN_W-1:0] HDR_BYTES = 10'd2;

   typedef enum logic [2:0] {
      K_APPEND = 3'd0,
      K_REJECT = 3'd1,
      K_CLEAR  = 3'd2,
      K_SCAN   = 3'd3,
      K_HEADER = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [LEN_W-1:0] length;
      logic             bad;
   } entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [PTR_W-1:0]  limit;
   } region_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  count;
      logic [LEN_W-1:0]  hval;
      logic [1:0]        status;
      logic              last;
   } result_type;

endpackage

`default_nettype wire

>>> sv/frlp_front.sv
`default_nettype none

module frlp_front import frlp_pkg::*; (
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [1:0] command,
   input  wire logic [15:0] record_length,
   input  wire logic [15:0] header_word,
   input  wire logic       q_full,
   output logic            q_push,
   output entry_type       entry
);

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;

   always_comb begin
      entry.kind   = K_APPEND;
      entry.length = record_length[LEN_W-1:0];
      entry.bad    = 1'b0;
      case (command)
         CMD_APPEND: begin
            if (record_length == 16'd0 || record_length > MAX_LEN) begin
               entry.kind = K_REJECT;
            end
         end
         CMD_CLEAR: begin
            entry.kind = K_CLEAR;
         end
         CMD_SCAN: begin
            entry.kind = K_SCAN;
         end
         CMD_HEADER: begin
            entry.kind   = K_HEADER;
            entry.length = header_word[LEN_W-1:0];
            entry.bad    = (header_word == ERASED_WORD) || (header_word < MIN_LEN) ||
                           (header_word > MAX_LEN);
         end
         default: begin
            entry.kind = K_REJECT;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/frlp_fifo.sv
`default_nettype none

module frlp_fifo import frlp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output entry_type      head
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_IDX) ? '0 : rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/frlp_back.sv
`default_nettype none
`include "flash_record_log_pointer_unit_macros.svh"

module frlp_back import frlp_pkg::*; #(
   parameter int MAX_SECTORS = MAX_REGION_SECTORS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire region_type region,
   input  wire logic       q_empty,
   input  wire entry_type  q_head,
   output logic            q_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp
);

   localparam int CNT_W = $clog2(MAX_SECTORS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_SECTORS);
   localparam logic [PTR_W-1:0] SECT_MASK = PTR_W'(SECTOR_BYTES - 1);
   localparam logic [PTR_W:0]   SECT_STEP = (PTR_W + 1)'(SECTOR_BYTES);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ERASE  = 7'b0000010,
      S_BOUND  = 7'b0000100,
      S_WHDR   = 7'b0001000,
      S_WPAY   = 7'b0010000,
      S_CHECK  = 7'b0100000,
      S_STATUS = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             scan_ff, scan_in;
   logic             clear_ff, clear_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0]       status_ff, status_in;
   logic [PTR_W-1:0] sweep_ff, sweep_in;
   logic [CNT_W-1:0] ecount_ff, ecount_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             out_free;
   logic [PTR_W:0]   head_end;
   logic             head_over;
   logic [PTR_W:0]   rec_end;
   logic [PTR_W:0]   hdr_end;
   logic             check_over;
   logic [PTR_W:0]   sweep_next;
   logic             sweep_live;
   logic             erase_last;
   logic [PTR_W-1:0] base_ptr;

   function automatic result_type make_result(input logic [2:0] op,
                                              input logic [PTR_W-1:0] addr,
                                              input logic [LEN_W-1:0] count,
                                              input logic [LEN_W-1:0] hval,
                                              input logic [1:0] status,
                                              input logic last);
      result_type r;
      r.op     = op;
      r.addr   = addr[ADDR_W-1:0];
      r.count  = count;
      r.hval   = hval;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign base_ptr   = {1'b0, region.base};
   assign head_end   = {1'b0, wp_ff} + (PTR_W + 1)'(2) + (PTR_W + 1)'(q_head.length);
   assign head_over  = head_end > {1'b0, region.limit};
   assign rec_end    = {1'b0, wp_ff} + (PTR_W + 1)'(2) + (PTR_W + 1)'(len_ff);
   assign hdr_end    = {1'b0, wp_ff} + (PTR_W + 1)'(2);
   assign check_over = hdr_end > {1'b0, region.limit};
   assign sweep_next = {1'b0, sweep_ff} + SECT_STEP;
   assign sweep_live = (sweep_ff < region.limit) && (ecount_ff < CNT_MAX);
   assign erase_last = clear_ff && ((sweep_next >= {1'b0, region.limit}) ||
                                    (ecount_ff + 1'b1 == CNT_MAX));

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      scan_in      = scan_ff;
      clear_in     = clear_ff;
      len_in       = len_ff;
      status_in    = status_ff;
      sweep_in     = sweep_ff;
      ecount_in    = ecount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               len_in = q_head.length;
               case (q_head.kind)
                  K_REJECT: begin
                     scan_in   = 1'b0;
                     status_in = STAT_REJECT;
                     state_in  = S_STATUS;
                  end
                  K_APPEND: begin
                     scan_in  = 1'b0;
                     clear_in = 1'b0;
                     if (head_over) begin
                        sweep_in  = base_ptr;
                        ecount_in = '0;
                        state_in  = S_ERASE;
                     end else begin
                        state_in = S_BOUND;
                     end
                  end
                  K_CLEAR: begin
                     scan_in   = 1'b0;
                     clear_in  = 1'b1;
                     sweep_in  = base_ptr;
                     ecount_in = '0;
                     state_in  = S_ERASE;
                  end
                  K_SCAN: begin
                     wp_in    = base_ptr;
                     scan_in  = 1'b1;
                     state_in = S_CHECK;
                  end
                  K_HEADER: begin
                     if (!scan_ff) begin
                        status_in = STAT_END;
                        state_in  = S_STATUS;
                     end else if (q_head.bad || head_over) begin
                        scan_in   = 1'b0;
                        status_in = STAT_END;
                        state_in  = S_STATUS;
                     end else begin
                        wp_in    = head_end[PTR_W-1:0];
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     status_in = STAT_REJECT;
                     state_in  = S_STATUS;
                  end
               endcase
            end
         end
         S_ERASE: begin
            if (sweep_live) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_result(OP_ERASE, sweep_ff, '0, '0, STAT_OK, erase_last);
                  sweep_in     = sweep_next[PTR_W-1:0];
                  ecount_in    = ecount_ff + 1'b1;
               end
            end else begin
               wp_in = base_ptr;
               if (!clear_ff) begin
                  state_in = S_BOUND;
               end else if (ecount_ff == '0) begin
                  status_in = STAT_OK;
                  state_in  = S_STATUS;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BOUND: begin
            if ((wp_ff & SECT_MASK) == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_result(OP_ERASE, wp_ff, '0, '0, STAT_OK, 1'b0);
                  state_in     = S_WHDR;
               end
            end else begin
               state_in = S_WHDR;
            end
         end
         S_WHDR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_result(OP_WHDR, wp_ff, HDR_BYTES, len_ff, STAT_OK, 1'b0);
               state_in     = S_WPAY;
            end
         end
         S_WPAY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_result(OP_WPAY, hdr_end[PTR_W-1:0], len_ff, '0, STAT_OK,
                                          1'b1);
               wp_in        = rec_end[PTR_W-1:0];
               state_in     = S_IDLE;
            end
         end
         S_CHECK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (check_over) begin
                  scan_in = 1'b0;
                  rsp_in  = make_result(OP_STATUS, wp_ff, '0, '0, STAT_END, 1'b1);
               end else begin
                  rsp_in  = make_result(OP_RHDR, wp_ff, HDR_BYTES, '0, STAT_OK, 1'b1);
               end
               state_in = S_IDLE;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_result(OP_STATUS, wp_ff, '0, '0, status_ff, 1'b1);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         scan_ff      <= 1'b0;
         ecount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         scan_ff      <= scan_in;
         ecount_ff    <= ecount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clear_ff  <= clear_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      sweep_ff  <= sweep_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_IMPLIES(pop_only_when_idle, clock, reset, q_pop, state_ff == S_IDLE)
   `ASSERT_NEXT(write_stops_scan, clock, reset, q_pop && (q_head.kind == K_APPEND || q_head.kind == K_CLEAR), !scan_ff)
   `ASSERT_IMPLIES(sweep_bounded, clock, reset, state_ff == S_ERASE, ecount_ff <= CNT_MAX)
   `ASSERT_IMPLIES(payload_ends_command, clock, reset, rsp_valid_ff && rsp_ff.op == OP_WPAY, rsp_ff.last)

endmodule

`default_nettype wire

>>> sv/flash_record_log_pointer_unit.sv
`default_nettype none
// Channel  Direction  tdata                                          tuser      tlast
// req_     in         record_length[15:0], header_word[31:16]        command    -
// rsp_     out        flash_address, byte_count, header_value,       operation  last_result
//                     result_status, zero fill
// csr_     in         write enable, register index, write data       -          -
//
// A command is one transfer into a queue of QUEUE_SLOTS entries; the back end pops one at a time.
// An append erases the sector at the pointer when the pointer is sector aligned, then writes
// the header and the payload; on a rollover it first erases the region sector by sector.
// A clear erases the region sector by sector, or gives a status result when the region is empty;
// every other command gives a single result.
// Results leave through a single output register; while it stalls the back end waits.
// Reset is synchronous and clears the pointer, the scan flag, the queue and the configuration registers.
// Configuration writes take effect on the next cycle and are meant for an idle unit.

module flash_record_log_pointer_unit import frlp_pkg::*; #(
   parameter int MAX_SECTORS = MAX_REGION_SECTORS,
   parameter int QUEUE_SLOTS = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // record_length [15:0], header_word [31:16]
   input  wire logic [1:0]  req_tuser,    // command [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,    // flash_address [23:0], byte_count [33:24],
                                          // header_value [43:34], result_status [45:44]
   output logic [2:0]       rsp_tuser,    // operation [2:0]
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [24:0] csr_wr_data
);

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;
   localparam logic [PTR_W-1:0] LIMIT_RESET = 25'd65536;

   region_type region_ff, region_in;
   entry_type  push_entry;
   entry_type  q_head;
   result_type rsp;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;

   always_comb begin
      region_in = region_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE:  region_in.base  = csr_wr_data[ADDR_W-1:0];
            CSR_LIMIT: region_in.limit = csr_wr_data;
            default:   region_in = region_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff.base  <= '0;
         region_ff.limit <= LIMIT_RESET;
      end else begin
         region_ff <= region_in;
      end
   end

   frlp_front u_front (
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .command       (req_tuser),
      .record_length (req_tdata[15:0]),
      .header_word   (req_tdata[31:16]),
      .q_full        (q_full),
      .q_push        (q_push),
      .entry         (push_entry)
   );

   frlp_fifo #(
      .DEPTH (QUEUE_SLOTS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   frlp_back #(
      .MAX_SECTORS (MAX_SECTORS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .region    (region_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {2'b00, rsp.status, rsp.hval, rsp.count, rsp.addr};
   assign rsp_tuser = rsp.op;
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire
